// ----- rtl/core/cfd_pkg.sv -----
// ----------------------------------------------------------------------------
// cfd_pkg
// Types, constants and arithmetic helpers shared by the colour fade dither
// fill core.
// ----------------------------------------------------------------------------
package cfd_pkg;

  localparam int LED_COUNT = 64;
  localparam int CNT_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  localparam logic OP_BLEND = 1'b0;
  localparam logic OP_FINAL = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] start_level;
    logic       start_on;
    logic [7:0] target_red;
    logic [7:0] target_green;
    logic [7:0] target_blue;
    logic [7:0] target_level;
    logic       target_on;
    logic [15:0] progress;
  } cfd_in_t;

  typedef struct packed {
    logic [5:0] led_index;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic       last_pixel;
  } cfd_out_t;

  typedef struct packed {
    logic [15:0] ch_red;
    logic [15:0] ch_green;
    logic [15:0] ch_blue;
    logic [15:0] bright;
  } cfd_lvl_t;

  typedef struct packed {
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
  } cfd_prod_t;

  typedef struct packed {
    logic [7:0]  px;
    logic [25:0] err;
  } cfd_dith_t;

  // Linear blend of two 8-bit values to 16 bits; the sum is never negative.
  function automatic logic [15:0] blend16(input logic [7:0] s, input logic [7:0] t,
                                          input logic [15:0] p);
    logic signed [8:0]  d;
    logic signed [25:0] v;
    d = $signed({1'b0, t}) - $signed({1'b0, s});
    v = $signed({2'b00, s, 16'h0000}) + d * $signed({1'b0, p});
    return v[23:8];
  endfunction

  // One error diffusion step: pixel saturated at 255, remainder carried.
  function automatic cfd_dith_t dither_step(input logic [31:0] prod,
                                            input logic [25:0] err);
    logic [32:0] v;
    logic [32:0] rem;
    cfd_dith_t   r;
    v     = {1'b0, prod} + {7'b0, err};
    r.px  = v[32] ? 8'hFF : v[31:24];
    rem   = v - {1'b0, r.px, 24'h000000};
    r.err = rem[25:0];
    return r;
  endfunction

endpackage

// ----- rtl/core/cfd_front.sv -----
// ----------------------------------------------------------------------------
// cfd_front
// Accepts fade steps, works out the 16-bit channel and brightness levels and
// forms the three channel products in a two-stage pipeline.
// ----------------------------------------------------------------------------
module cfd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cfd_pkg::cfd_in_t   in_data,
  output logic               q_valid,
  input  logic               q_ready,
  output cfd_pkg::cfd_prod_t q_data
);
  import cfd_pkg::*;

  logic      s1_v_r, s1_v_nxt;
  logic      s2_v_r, s2_v_nxt;
  cfd_lvl_t  s1_r, s1_nxt;
  cfd_prod_t s2_r, s2_nxt;
  logic      s1_take, s2_take;
  logic [7:0] s_lvl, t_lvl;

  assign s2_take  = !s2_v_r || q_ready;
  assign s1_take  = !s1_v_r || s2_take;
  assign in_ready = s1_take;
  assign q_valid  = s2_v_r;
  assign q_data   = s2_r;

  assign s_lvl = in_data.start_on  ? in_data.start_level  : 8'h00;
  assign t_lvl = in_data.target_on ? in_data.target_level : 8'h00;

  always_comb begin
    s1_v_nxt = s1_take ? in_valid : s1_v_r;
    s1_nxt   = s1_r;
    if (in_valid && s1_take) begin
      if (in_data.opcode == OP_BLEND) begin
        s1_nxt.ch_red   = blend16(in_data.src_red,   in_data.target_red,   in_data.progress);
        s1_nxt.ch_green = blend16(in_data.src_green, in_data.target_green, in_data.progress);
        s1_nxt.ch_blue  = blend16(in_data.src_blue,  in_data.target_blue,  in_data.progress);
        s1_nxt.bright   = blend16(s_lvl, t_lvl, in_data.progress);
      end else begin
        s1_nxt.ch_red   = {in_data.target_red,   8'h00};
        s1_nxt.ch_green = {in_data.target_green, 8'h00};
        s1_nxt.ch_blue  = {in_data.target_blue,  8'h00};
        s1_nxt.bright   = {t_lvl, 8'h00};
      end
    end
  end

  always_comb begin
    s2_v_nxt = s2_take ? s1_v_r : s2_v_r;
    s2_nxt   = s2_r;
    if (s1_v_r && s2_take) begin
      s2_nxt.red   = {16'h0000, s1_r.ch_red}   * {16'h0000, s1_r.bright};
      s2_nxt.green = {16'h0000, s1_r.ch_green} * {16'h0000, s1_r.bright};
      s2_nxt.blue  = {16'h0000, s1_r.ch_blue}  * {16'h0000, s1_r.bright};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    s2_r <= s2_nxt;
  end

endmodule

// ----- rtl/core/cfd_queue.sv -----
// ----------------------------------------------------------------------------
// cfd_queue
// Two-entry queue of channel products between the front and back parts.
// ----------------------------------------------------------------------------
module cfd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  cfd_pkg::cfd_prod_t push_data,
  output logic               pop_valid,
  input  logic               pop,
  output cfd_pkg::cfd_prod_t pop_data
);
  import cfd_pkg::*;

  cfd_prod_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/core/cfd_back.sv -----
// ----------------------------------------------------------------------------
// cfd_back
// Walks the strip for the item at the head of the queue, carrying the
// quantisation error of each channel from LED to LED.
// ----------------------------------------------------------------------------
module cfd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  cfd_pkg::cfd_prod_t q_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cfd_pkg::cfd_out_t  out_data
);
  import cfd_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [25:0]      err_r [3];
  logic [25:0]      err_nxt [3];
  logic             out_valid_r, out_valid_nxt;
  cfd_out_t         out_data_r, out_data_nxt;
  cfd_dith_t        d_red, d_green, d_blue;
  logic             emit, last;

  assign emit  = q_valid && (!out_valid_r || out_ready);
  assign last  = (cnt_r == CNT_W'(LED_COUNT - 1));
  assign q_pop = emit && last;

  assign d_red   = dither_step(q_data.red,   err_r[0]);
  assign d_green = dither_step(q_data.green, err_r[1]);
  assign d_blue  = dither_step(q_data.blue,  err_r[2]);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (emit) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.led_index   = 6'(cnt_r);
      out_data_nxt.pixel_red   = d_red.px;
      out_data_nxt.pixel_green = d_green.px;
      out_data_nxt.pixel_blue  = d_blue.px;
      out_data_nxt.last_pixel  = last;
      if (last) begin
        cnt_nxt    = '0;
        err_nxt[0] = '0;
        err_nxt[1] = '0;
        err_nxt[2] = '0;
      end else begin
        cnt_nxt    = cnt_r + 1'b1;
        err_nxt[0] = d_red.err;
        err_nxt[1] = d_green.err;
        err_nxt[2] = d_blue.err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      err_r[0]    <= '0;
      err_r[1]    <= '0;
      err_r[2]    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- rtl/core/color_fade_dither_fill_core.sv -----
// ----------------------------------------------------------------------------
// color_fade_dither_fill_core
// Turns one fade step of an RGB strip into a dithered pixel for every LED.
//
// The input channel (in_valid, in_ready, in_data) takes one fade step per
// beat: start and target colour, brightness, on flags, opcode and progress.
// The result channel (out_valid, out_ready, out_data) gives LED_COUNT beats
// per step, one pixel each, in LED order, with last_pixel on the final LED.
// The first pixel of a step passes through the level stage, the product
// stage, the queue and the output register. The back part emits one
// pixel per cycle unless out_ready stalls it; that single dithering walk
// over all LED_COUNT LEDs (64 here) sets the sustained step rate. The
// front part computes levels and products in two stages and queues up to two
// steps, so new ones are taken while earlier ones are still being walked out.
// A stall on out_ready holds the current pixel and pauses the walk; the
// queue then fills and in_ready falls. A synchronous reset on rst_n empties
// every stage and the queue and clears the carried errors.
// ----------------------------------------------------------------------------
module color_fade_dither_fill_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cfd_pkg::cfd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cfd_pkg::cfd_out_t out_data
);
  import cfd_pkg::*;

  logic      f_valid, f_ready;
  cfd_prod_t f_data;
  logic      b_valid, b_pop;
  cfd_prod_t b_data;

  cfd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_data   (f_data)
  );

  cfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop        (b_pop),
    .pop_data   (b_data)
  );

  cfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (b_valid),
    .q_pop     (b_pop),
    .q_data    (b_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/cfd_checker.sv -----
// ----------------------------------------------------------------------------
// cfd_checker
// Port-level checks on the colour fade dither fill core, bound to the top.
// ----------------------------------------------------------------------------
module cfd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input cfd_pkg::cfd_out_t out_data
);
  import cfd_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_walk_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_pixel |=>
      out_valid && out_data.led_index == $past(out_data.led_index) + 6'd1)
    else $error("strip walk skipped or paused");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_pixel |-> out_data.led_index == 6'(LED_COUNT - 1))
    else $error("last pixel on wrong LED");

endmodule

bind color_fade_dither_fill_core cfd_checker u_cfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
